@@ rtl/core/assert_macros.svh @@
// Concurrent assertion helpers used by the checker file pthe_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pthe_pkg.sv @@
package pthe_pkg;

  localparam int SET_BITS_MAX_DEF = 10;
  localparam int WAY_BITS_MAX_DEF = 3;
  localparam int ADDR_W_DEF       = 48;

  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 3;
  localparam int OFFSET_W = 6;
  localparam int SETB_W   = 4;
  localparam int WAYB_W   = 2;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 4;
  localparam int RIDX_W     = 2;

  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISALIGN = 3'd4;

  localparam logic [RIDX_W-1:0] REG_TABLE_KIND = 2'd0;
  localparam logic [RIDX_W-1:0] REG_OFFSET     = 2'd1;
  localparam logic [RIDX_W-1:0] REG_SET_BITS  = 2'd2;
  localparam logic [RIDX_W-1:0] REG_WAY_BITS  = 2'd3;

  localparam logic                RST_TABLE_KIND = 1'b0;
  localparam logic [OFFSET_W-1:0] RST_OFFSET     = 6'd12;
  localparam logic [SETB_W-1:0]   RST_SET_BITS   = 4'd10;
  localparam logic [WAYB_W-1:0]   RST_WAY_BITS   = 2'd2;

  typedef struct packed {
    logic                table_kind;
    logic [OFFSET_W-1:0] page_shift;
    logic [SETB_W-1:0]   set_index_bits;
    logic [WAYB_W-1:0]   way_index_bits;
  } cfg_t;

endpackage

@@ rtl/core/pthe_probe.sv @@
module pthe_probe #(
  parameter int SET_BITS_MAX = pthe_pkg::SET_BITS_MAX_DEF,
  parameter int WAY_BITS_MAX = pthe_pkg::WAY_BITS_MAX_DEF,
  parameter int ADDR_W       = pthe_pkg::ADDR_W_DEF,
  localparam int SLOT_BITS   = SET_BITS_MAX + WAY_BITS_MAX,
  localparam int CNT_W       = SLOT_BITS + 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pthe_pkg::cfg_t                   cfg,
  input  logic                             start,
  output logic                             ready,
  input  logic [pthe_pkg::OPCODE_W-1:0]    opcode,
  input  logic [ADDR_W-1:0]                page_address,
  input  logic [SLOT_BITS-1:0]             slot_to_clear,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [pthe_pkg::STATUS_W-1:0]    res_status,
  output logic [SLOT_BITS-1:0]             res_slot,
  output logic [CNT_W-1:0]                 res_used,
  output logic [CNT_W-1:0]                 res_probe
);
  import pthe_pkg::*;

  localparam int SLOTS = 1 << SLOT_BITS;
  localparam int SB_W  = $clog2(SET_BITS_MAX + 2);
  localparam int WB_W  = $clog2(WAY_BITS_MAX + 2);
  localparam int SH_W  = ADDR_W + SLOT_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_READ, S_TEST, S_REPLY
  } state_t;

  state_t                state;
  logic [OPCODE_W-1:0]   op;
  logic [ADDR_W-1:0]     addr;
  logic [SLOT_BITS-1:0]  clr_slot;
  logic [SLOT_BITS-1:0]  slot;
  logic [SLOT_BITS-1:0]  slot_out;
  logic [CNT_W-1:0]      remain;
  logic [CNT_W-1:0]      hops;
  logic [CNT_W-1:0]      used_count;
  logic [CNT_W-1:0]      probe_limit;
  logic [STATUS_W-1:0]   status;

  logic [ADDR_W:0]       tag_mem [SLOTS];
  logic [ADDR_W:0]       rd_data;
  logic                  mem_we;
  logic [SLOT_BITS-1:0]  mem_wa;
  logic [ADDR_W:0]       mem_wd;

  logic [SB_W-1:0]       sb_eff;
  logic [WB_W-1:0]       wb_eff;
  logic [SLOT_BITS-1:0]  set_mask;
  logic [CNT_W-1:0]      capacity;
  logic [CNT_W-1:0]      ways;
  logic [CNT_W-1:0]      probe_n;
  logic [SH_W-1:0]       shifted;
  logic [SLOT_BITS-1:0]  home;
  logic [SLOT_BITS-1:0]  home_way0;
  logic                  misaligned;
  logic                  is_insert;
  logic                  tag_valid;
  logic                  tag_match;
  logic                  free_hit;
  logic                  found;
  logic                  dup;

  always_comb begin
    if (32'(cfg.set_index_bits) > SET_BITS_MAX) begin
      sb_eff = SB_W'(SET_BITS_MAX);
    end else begin
      sb_eff = SB_W'(cfg.set_index_bits);
    end
    if (cfg.table_kind) begin
      wb_eff = '0;
    end else if (32'(cfg.way_index_bits) > WAY_BITS_MAX) begin
      wb_eff = WB_W'(WAY_BITS_MAX);
    end else begin
      wb_eff = WB_W'(cfg.way_index_bits);
    end
  end

  assign set_mask   = ~({SLOT_BITS{1'b1}} << sb_eff);
  assign capacity   = CNT_W'(1) << (int'(sb_eff) + int'(wb_eff));
  assign ways       = CNT_W'(1) << wb_eff;
  assign probe_n    = (probe_limit < capacity) ? probe_limit : capacity;
  assign shifted    = {{SLOT_BITS{1'b0}}, addr} >> cfg.page_shift;
  assign home       = shifted[SLOT_BITS-1:0] & set_mask;
  assign home_way0  = home << wb_eff;
  assign misaligned = (addr & ~({ADDR_W{1'b1}} << cfg.page_shift)) != '0;

  assign is_insert = (op == OP_INSERT);
  assign tag_valid = rd_data[ADDR_W];
  assign tag_match = (rd_data[ADDR_W-1:0] == addr);
  assign free_hit  = is_insert && !tag_valid;
  assign found     = !is_insert && tag_valid && tag_match;
  assign dup       = is_insert && cfg.table_kind && tag_valid && tag_match;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot;
    mem_wd = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_DECODE && op == OP_REMOVE) begin
      mem_we = 1'b1;
      mem_wa = clr_slot;
    end else if (state == S_TEST && free_hit) begin
      mem_we = 1'b1;
      mem_wd = {1'b1, addr};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_wa] <= mem_wd;
    end
    rd_data <= tag_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      slot        <= '0;
      used_count  <= '0;
      probe_limit <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          slot <= slot + 1'b1;
          if (&slot) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op       <= opcode;
            addr     <= page_address;
            clr_slot <= slot_to_clear;
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          hops     <= '0;
          slot_out <= (op == OP_REMOVE) ? clr_slot : '0;
          if (op == OP_REMOVE) begin
            if (used_count != '0) begin
              used_count <= used_count - 1'b1;
            end
            status <= ST_OK;
            state  <= S_REPLY;
          end else if (op != OP_LOOKUP && op != OP_INSERT) begin
            status <= ST_MISS;
            state  <= S_REPLY;
          end else if (misaligned) begin
            status <= ST_MISALIGN;
            state  <= S_REPLY;
          end else if (!is_insert && cfg.table_kind && probe_n == '0) begin
            status <= ST_MISS;
            state  <= S_REPLY;
          end else if (is_insert && used_count >= capacity) begin
            status <= ST_FULL;
            state  <= S_REPLY;
          end else begin
            slot  <= cfg.table_kind ? home : home_way0;
            state <= S_READ;
            if (!cfg.table_kind) begin
              remain <= ways;
            end else if (is_insert) begin
              remain <= capacity;
            end else begin
              remain <= probe_n;
            end
          end
        end
        S_READ: begin
          state <= S_TEST;
        end
        S_TEST: begin
          if (free_hit) begin
            used_count <= used_count + 1'b1;
            if (cfg.table_kind && (hops + 1'b1) > probe_limit) begin
              probe_limit <= hops + 1'b1;
            end
            status   <= ST_OK;
            slot_out <= slot;
            state    <= S_REPLY;
          end else if (found) begin
            status   <= ST_OK;
            slot_out <= slot;
            state    <= S_REPLY;
          end else if (dup) begin
            status <= ST_DUP;
            state  <= S_REPLY;
          end else if (remain == CNT_W'(1)) begin
            status <= is_insert ? ST_FULL : ST_MISS;
            state  <= S_REPLY;
          end else begin
            remain <= remain - 1'b1;
            hops   <= hops + 1'b1;
            slot   <= cfg.table_kind ? ((slot + 1'b1) & set_mask) : (slot + 1'b1);
            state  <= S_READ;
          end
        end
        S_REPLY: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ready      = (state == S_IDLE);
  assign res_valid  = (state == S_REPLY);
  assign res_status = status;
  assign res_slot   = slot_out;
  assign res_used   = used_count;
  assign res_probe  = probe_limit;

endmodule

@@ rtl/core/page_table_hash_engine.sv @@
// channel  | dir | handshake                | payload
// s_*      | in  | s_tvalid / s_tready      | tuser: opcode; tdata: page_address, slot_to_clear
// m_*      | out | m_tvalid / m_tready      | tuser: status; tdata: slot, used, probe
// apb      | in  | psel, penable, pready=1  | registers at byte 0, 4, 8, 12
//
// After reset the tag RAM is swept clean, one slot a cycle, over all 2**(SET_BITS_MAX+WAY_BITS_MAX)
// slots (8192 by default), with s_tready low.
// Remove, reserved opcode, misaligned, early miss or early-full: accept, S_DECODE, then result in S_REPLY.
// Lookup and insert: S_DECODE, then S_READ and S_TEST for each slot probed, then S_REPLY, paced by
// the registered read of the tag RAM (one read, one write port) and the one tag comparator.
// A finished result sits in the output register; the next transaction is taken meanwhile,
// and the engine holds its own result only while that register is still full.
module page_table_hash_engine #(
  parameter int SET_BITS_MAX = pthe_pkg::SET_BITS_MAX_DEF,
  parameter int WAY_BITS_MAX = pthe_pkg::WAY_BITS_MAX_DEF,
  parameter int ADDR_W       = pthe_pkg::ADDR_W_DEF,
  localparam int SLOT_BITS   = SET_BITS_MAX + WAY_BITS_MAX,
  localparam int CNT_W       = SLOT_BITS + 1,
  localparam int S_DATA_W    = ((ADDR_W + SLOT_BITS + 7) / 8) * 8,
  localparam int M_DATA_W    = ((SLOT_BITS + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // page_address, slot_to_clear, zero pad
  input  logic [S_DATA_W-1:0]               s_tdata,
  // opcode
  input  logic [pthe_pkg::OPCODE_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // slot_index, entries_used, longest_probe, zero pad
  output logic [M_DATA_W-1:0]               m_tdata,
  // status
  output logic [pthe_pkg::STATUS_W-1:0]     m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pthe_pkg::PADDR_W-1:0]      paddr,
  input  logic [pthe_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pthe_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import pthe_pkg::*;

  cfg_t                  cfg;
  logic [RIDX_W-1:0]     reg_idx;
  logic                  cfg_wr;
  logic                  core_ready;
  logic                  res_valid;
  logic                  res_ready;
  logic [STATUS_W-1:0]   res_status;
  logic [SLOT_BITS-1:0]  res_slot;
  logic [CNT_W-1:0]      res_used;
  logic [CNT_W-1:0]      res_probe;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:PADDR_W-RIDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_kind     <= RST_TABLE_KIND;
      cfg.page_shift     <= RST_OFFSET;
      cfg.set_index_bits <= RST_SET_BITS;
      cfg.way_index_bits <= RST_WAY_BITS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TABLE_KIND: cfg.table_kind     <= pwdata[0];
        REG_OFFSET:     cfg.page_shift     <= pwdata[OFFSET_W-1:0];
        REG_SET_BITS:   cfg.set_index_bits <= pwdata[SETB_W-1:0];
        REG_WAY_BITS:   cfg.way_index_bits <= pwdata[WAYB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TABLE_KIND: prdata = APB_DATA_W'(cfg.table_kind);
      REG_OFFSET:     prdata = APB_DATA_W'(cfg.page_shift);
      REG_SET_BITS:   prdata = APB_DATA_W'(cfg.set_index_bits);
      REG_WAY_BITS:   prdata = APB_DATA_W'(cfg.way_index_bits);
      default:        prdata = '0;
    endcase
  end

  assign s_tready = core_ready;

  pthe_probe #(
    .SET_BITS_MAX (SET_BITS_MAX),
    .WAY_BITS_MAX (WAY_BITS_MAX),
    .ADDR_W       (ADDR_W)
  ) u_probe (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .start         (s_tvalid && s_tready),
    .ready         (core_ready),
    .opcode        (s_tuser),
    .page_address  (s_tdata[ADDR_W-1:0]),
    .slot_to_clear (s_tdata[ADDR_W +: SLOT_BITS]),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_status    (res_status),
    .res_slot      (res_slot),
    .res_used      (res_used),
    .res_probe     (res_probe)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
      m_tuser  <= res_status;
      m_tdata  <= M_DATA_W'({res_probe, res_used, res_slot});
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/pthe_checker.sv @@
`include "assert_macros.svh"

module pthe_checker #(
  parameter int SET_BITS_MAX = pthe_pkg::SET_BITS_MAX_DEF,
  parameter int WAY_BITS_MAX = pthe_pkg::WAY_BITS_MAX_DEF,
  localparam int SLOT_BITS   = SET_BITS_MAX + WAY_BITS_MAX,
  localparam int CNT_W       = SLOT_BITS + 1,
  localparam int M_DATA_W    = ((SLOT_BITS + 2 * CNT_W + 7) / 8) * 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [M_DATA_W-1:0]           m_tdata,
  input logic [pthe_pkg::STATUS_W-1:0] m_tuser
);
  import pthe_pkg::*;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(1) << SLOT_BITS;

  `ASSERT_SAME(a_slot_zero_on_fail, clk, rst,
    m_tvalid && m_tuser != ST_OK, m_tdata[SLOT_BITS-1:0] == '0, "slot set on failed status")
  `ASSERT_SAME(a_used_bound, clk, rst,
    m_tvalid, m_tdata[SLOT_BITS +: CNT_W] <= SLOTS_CNT, "entries_used above table size")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst,
    s_tvalid && s_tready, !s_tready, "new transaction taken while busy")
  `ASSERT_NEXT(a_out_hold, clk, rst,
    m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result dropped")

endmodule

bind page_table_hash_engine pthe_checker #(
  .SET_BITS_MAX (SET_BITS_MAX),
  .WAY_BITS_MAX (WAY_BITS_MAX)
) u_pthe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ sim/page_table_hash_engine_tb.sv @@
module page_table_hash_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pthe_pkg::*;

  localparam int ADDR_W     = ADDR_W_DEF;
  localparam int SLOT_W     = SET_BITS_MAX_DEF + WAY_BITS_MAX_DEF;
  localparam int CNT_W      = SLOT_W + 1;
  localparam int SLOTS      = 1 << SLOT_W;
  localparam int S_DATA_W   = ((ADDR_W + SLOT_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((SLOT_W + 2 * CNT_W + 7) / 8) * 8;
  localparam int LONG_HOLD  = 300;
  localparam int STALL_MAX  = 30000;
  localparam int POOL_N     = 12;

  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    used;
    logic [CNT_W-1:0]    probe;
  } tag_outcome_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [1:0]          code;
    logic [ADDR_W-1:0]   word;
    logic [SLOT_W-1:0]   clr;
    logic                typed;
    logic [STATUS_W-1:0] t_status;
    logic [SLOT_W-1:0]   t_slot;
  } dir_row_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  off;
    logic [3:0]  sb;
    logic [1:0]  wb;
    logic [15:0] n;
  } phase_t;

  localparam int DIR_N = 34;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{ROW_ITEM, OP_LOOKUP,      48'h0,              13'h0,    1'b1, ST_MISS,     13'd0},
    '{ROW_ITEM, OP_RESERVED,    48'hFFFF_FFFF_FFFF, 13'h1FFF, 1'b1, ST_MISS,     13'd0},
    '{ROW_ITEM, OP_LOOKUP,      48'h0000_0000_0800, 13'h0,    1'b1, ST_MISALIGN, 13'd0},
    '{ROW_ITEM, OP_INSERT,      48'h0,              13'h0,    1'b1, ST_OK,       13'd0},
    '{ROW_ITEM, OP_INSERT,      48'h0,              13'h0,    1'b1, ST_OK,       13'd1},
    '{ROW_ITEM, OP_LOOKUP,      48'h0,              13'h0,    1'b1, ST_OK,       13'd0},
    '{ROW_ITEM, OP_INSERT,      48'hFFFF_FFFF_F000, 13'h0,    1'b1, ST_OK,       13'd4092},
    '{ROW_ITEM, OP_LOOKUP,      48'hFFFF_FFFF_F000, 13'h0,    1'b1, ST_OK,       13'd4092},
    '{ROW_ITEM, OP_INSERT,      48'hAAAA_AAAA_A000, 13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_INSERT,      48'h5555_5555_5000, 13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_INSERT,      48'hFFFF_FFFF_FFFF, 13'h0,    1'b1, ST_MISALIGN, 13'd0},
    '{ROW_ITEM, OP_REMOVE,      48'h0,              13'h1FFF, 1'b1, ST_OK,       13'h1FFF},
    '{ROW_ITEM, OP_REMOVE,      48'h0,              13'h0AAA, 1'b1, ST_OK,       13'h0AAA},
    '{ROW_ITEM, OP_REMOVE,      48'h0,              13'h1555, 1'b1, ST_OK,       13'h1555},
    '{ROW_REG,  REG_TABLE_KIND, 48'd1,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_REG,  REG_OFFSET,     48'd0,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_REG,  REG_SET_BITS,   48'd2,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_REG,  REG_WAY_BITS,   48'd3,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_INSERT,      48'h1,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_INSERT,      48'h1,              13'h0,    1'b1, ST_DUP,      13'd0},
    '{ROW_ITEM, OP_LOOKUP,      48'h1,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_INSERT,      48'h7,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_INSERT,      48'h6,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_REMOVE,      48'h0,              13'h3,    1'b1, ST_OK,       13'd3},
    '{ROW_ITEM, OP_INSERT,      48'h6,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_REG,  REG_TABLE_KIND, 48'd0,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_REG,  REG_OFFSET,     48'd63,             13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_REG,  REG_SET_BITS,   48'd15,             13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_INSERT,      48'h1,              13'h0,    1'b1, ST_MISALIGN, 13'd0},
    '{ROW_ITEM, OP_INSERT,      48'h0,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_LOOKUP,      48'h0,              13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_REG,  REG_OFFSET,     48'd47,             13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_INSERT,      48'h8000_0000_0000, 13'h0,    1'b0, ST_OK,       13'd0},
    '{ROW_ITEM, OP_LOOKUP,      48'h4000_0000_0000, 13'h0,    1'b1, ST_MISALIGN, 13'd0}
  };

  localparam int PHASE_N = 9;
  localparam phase_t PHASES [PHASE_N] = '{
    '{1'b0, 6'd12, 4'd2,  2'd1, 16'd250},
    '{1'b1, 6'd4,  4'd3,  2'd0, 16'd250},
    '{1'b0, 6'd0,  4'd0,  2'd0, 16'd150},
    '{1'b1, 6'd20, 4'd4,  2'd2, 16'd250},
    '{1'b0, 6'd63, 4'd15, 2'd3, 16'd150},
    '{1'b1, 6'd47, 4'd1,  2'd1, 16'd150},
    '{1'b0, 6'd12, 4'd10, 2'd2, 16'd250},
    '{1'b1, 6'd12, 4'd10, 2'd3, 16'd200},
    '{1'b0, 6'd8,  4'd5,  2'd3, 16'd150}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // page_address, slot_to_clear, zero pad
  logic [S_DATA_W-1:0]   s_tdata = '0;
  // opcode
  logic [OPCODE_W-1:0]   s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // slot_index, entries_used, longest_probe, zero pad
  logic [M_DATA_W-1:0]   m_tdata;
  // status
  logic [STATUS_W-1:0]   m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  page_table_hash_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  cfg_t           cfg = '{RST_TABLE_KIND, RST_OFFSET, RST_SET_BITS, RST_WAY_BITS};
  bit             tag_live [SLOTS];
  bit [ADDR_W-1:0] tag_page [SLOTS];
  int             used_n = 0;
  int             probe_max = 0;
  tag_outcome_t   pending_outcomes [$];
  int             errors = 0;
  int             idle_pct = 0;
  bit             long_hold_req = 1'b0;
  int             stall_cycles = 0;

  function automatic tag_outcome_t outcome(logic [STATUS_W-1:0] st, int slot);
    tag_outcome_t r;
    r.status = st;
    r.slot   = (st == ST_OK) ? SLOT_W'(slot) : '0;
    r.used   = CNT_W'(used_n);
    r.probe  = CNT_W'(probe_max);
    return r;
  endfunction

  function automatic int set_bits_now();
    return (cfg.set_index_bits > SET_BITS_MAX_DEF) ? SET_BITS_MAX_DEF : int'(cfg.set_index_bits);
  endfunction

  function automatic int way_bits_now();
    if (cfg.table_kind) return 0;
    return (cfg.way_index_bits > WAY_BITS_MAX_DEF) ? WAY_BITS_MAX_DEF : int'(cfg.way_index_bits);
  endfunction

  function automatic tag_outcome_t walk_tags(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] pa,
                                             logic [SLOT_W-1:0] clr);
    int sb;
    int wb;
    int cap;
    int smask;
    int home;
    int s;
    int n;
    logic [ADDR_W-1:0] omask;
    sb    = set_bits_now();
    wb    = way_bits_now();
    cap   = 1 << (sb + wb);
    smask = (1 << sb) - 1;
    if (op == OP_REMOVE) begin
      if (used_n > 0) used_n--;
      tag_live[clr] = 1'b0;
      tag_page[clr] = '0;
      return outcome(ST_OK, int'(clr));
    end
    if (op == OP_RESERVED) return outcome(ST_MISS, 0);
    if (cfg.page_shift >= ADDR_W) begin
      omask = '1;
      home  = 0;
    end else begin
      omask = (ADDR_W'(1) << cfg.page_shift) - ADDR_W'(1);
      home  = int'(pa >> cfg.page_shift) & smask;
    end
    if ((pa & omask) != '0) return outcome(ST_MISALIGN, 0);
    if (op == OP_LOOKUP) begin
      if (!cfg.table_kind) begin
        for (int i = 0; i < (1 << wb); i++) begin
          s = (home << wb) | i;
          if (tag_live[s] && tag_page[s] == pa) return outcome(ST_OK, s);
        end
      end else begin
        n = (probe_max < cap) ? probe_max : cap;
        s = home;
        for (int i = 0; i < n; i++) begin
          if (tag_live[s] && tag_page[s] == pa) return outcome(ST_OK, s);
          s = (s + 1) & smask;
        end
      end
      return outcome(ST_MISS, 0);
    end
    if (used_n >= cap) return outcome(ST_FULL, 0);
    if (!cfg.table_kind) begin
      for (int i = 0; i < (1 << wb); i++) begin
        s = (home << wb) | i;
        if (!tag_live[s]) begin
          tag_live[s] = 1'b1;
          tag_page[s] = pa;
          used_n++;
          return outcome(ST_OK, s);
        end
      end
    end else begin
      s = home;
      for (int i = 0; i < cap; i++) begin
        if (!tag_live[s]) begin
          tag_live[s] = 1'b1;
          tag_page[s] = pa;
          used_n++;
          if (i + 1 > probe_max) probe_max = i + 1;
          return outcome(ST_OK, s);
        end
        if (tag_page[s] == pa) return outcome(ST_DUP, 0);
        s = (s + 1) & smask;
      end
    end
    return outcome(ST_FULL, 0);
  endfunction

  function automatic void flag_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function automatic logic [ADDR_W-1:0] align_page(logic [ADDR_W-1:0] a);
    if (cfg.page_shift >= ADDR_W) return '0;
    return a & ~((ADDR_W'(1) << cfg.page_shift) - ADDR_W'(1));
  endfunction

  task automatic offer(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] pa,
                       input logic [SLOT_W-1:0] clr, input logic typed,
                       input logic [STATUS_W-1:0] t_status, input logic [SLOT_W-1:0] t_slot);
    int gap;
    tag_outcome_t r;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(S_DATA_W - ADDR_W - SLOT_W){1'b0}}, clr, pa};
    do @(posedge clk); while (!s_tready);
    r = walk_tags(op, pa, clr);
    if (typed) begin
      r.status = t_status;
      r.slot   = t_slot;
    end
    pending_outcomes.push_back(r);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_TABLE_KIND: cfg.table_kind     = val[0];
      REG_OFFSET:     cfg.page_shift     = val[OFFSET_W-1:0];
      REG_SET_BITS:   cfg.set_index_bits = val[SETB_W-1:0];
      default:        cfg.way_index_bits = val[WAYB_W-1:0];
    endcase
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    flag_field("prdata", val, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : result_side
    int hold;
    tag_outcome_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected transaction: status %0d, tdata %h", $time, m_tuser, m_tdata);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          flag_field("status", want.status, m_tuser);
          flag_field("slot_index", want.slot, m_tdata[SLOT_W-1:0]);
          flag_field("entries_used", want.used, m_tdata[SLOT_W +: CNT_W]);
          flag_field("longest_probe", want.probe, m_tdata[SLOT_W + CNT_W +: CNT_W]);
        end
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        hold = $urandom_range(1, 4) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int pick;
    int span;
    int smask;
    logic [OPCODE_W-1:0] op;
    logic [ADDR_W-1:0] pa;
    logic [SLOT_W-1:0] clr;
    logic [ADDR_W-1:0] pool [POOL_N];
    dir_row_t row;
    phase_t ph;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 20;
    for (int d = 0; d < DIR_N; d++) begin
      row = DIRECTED[d];
      if (row.kind == ROW_REG) set_register(row.code, APB_DATA_W'(row.word));
      else offer(row.code, row.word, row.clr, row.typed, row.t_status, row.t_slot);
    end

    for (int p = 0; p < PHASE_N; p++) begin
      ph = PHASES[p];
      idle_pct = 0;
      set_register(REG_TABLE_KIND, APB_DATA_W'(ph.kind));
      set_register(REG_OFFSET, APB_DATA_W'(ph.off));
      set_register(REG_SET_BITS, APB_DATA_W'(ph.sb));
      set_register(REG_WAY_BITS, APB_DATA_W'(ph.wb));
      idle_pct = (p == PHASE_N - 1) ? 0 : 10 * $urandom_range(0, 3);
      span  = 1 << (set_bits_now() + way_bits_now());
      smask = (1 << set_bits_now()) - 1;
      // crowd half of the pool into the first few sets
      for (int k = 0; k < POOL_N; k++) begin
        pool[k] = align_page(ADDR_W'({$urandom, $urandom}));
        if (k[0] && cfg.page_shift < ADDR_W)
          pool[k] = (pool[k] & ~(ADDR_W'(smask) << cfg.page_shift)) |
                    ((ADDR_W'($urandom_range(0, 3)) & ADDR_W'(smask)) << cfg.page_shift);
      end
      if (p == 0) long_hold_req = 1'b1;
      for (int k = 0; k < ph.n; k++) begin
        pick = $urandom_range(0, 99);
        op = (pick < 35) ? OP_LOOKUP : (pick < 75) ? OP_INSERT :
             (pick < 95) ? OP_REMOVE : OP_RESERVED;
        pick = $urandom_range(0, 99);
        if (pick < 80) pa = pool[$urandom_range(0, POOL_N - 1)];
        else if (pick < 90) pa = align_page(ADDR_W'({$urandom, $urandom}));
        else pa = ADDR_W'({$urandom, $urandom});
        clr = ($urandom_range(0, 99) < 70) ? SLOT_W'($urandom_range(0, span - 1))
                                            : SLOT_W'($urandom);
        offer(op, pa, clr, 1'b0, ST_OK, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
